/* sv/btl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV tag locator package
// Shared codes, constants and the result word type.
// ----------------------------------------------------------------------------
package btl_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned OutW    = 40;   // 2 + 16 + 16, padded to whole bytes

  localparam logic [ByteW-1:0] TargetTagReset = 8'h82;
  localparam logic [ByteW-1:0] LongFormBit    = 8'h80;
  localparam logic [ByteW-1:0] LenCountMask   = 8'h7F;
  localparam logic [ByteW-1:0] TagAppl0       = 8'h60;
  localparam logic [ByteW-1:0] TagCtx2        = 8'hA2;
  localparam logic [6:0]       MaxLenBytes    = 7'd2;

  // parser phases
  localparam logic [PhaseW-1:0] PhTag   = 3'd0;
  localparam logic [PhaseW-1:0] PhLen   = 3'd1;
  localparam logic [PhaseW-1:0] PhLenx  = 3'd2;
  localparam logic [PhaseW-1:0] PhSkip  = 3'd3;
  localparam logic [PhaseW-1:0] PhValue = 3'd4;
  localparam logic [PhaseW-1:0] PhDone  = 3'd5;

  // result status codes
  localparam logic [StatusW-1:0] StFound   = 2'd0;
  localparam logic [StatusW-1:0] StAbsent  = 2'd1;
  localparam logic [StatusW-1:0] StLongLen = 2'd2;
  localparam logic [StatusW-1:0] StTrunc   = 2'd3;

  typedef struct packed {
    logic [PosW-1:0]    value_length;
    logic [PosW-1:0]    value_offset;
    logic [StatusW-1:0] status;
  } btl_result_t;

endpackage

/* sv/ber_tlv_tag_locator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV tag locator
// Scans one BER encoded APDU per frame and reports the first target tag.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Contents
// s_axis    in   s_axis_tvalid/tready   tdata: data_byte; tlast: last
// m_axis    out  m_axis_tvalid/tready   tdata: status, value_offset, value_length
// cfg       in   cfg_valid_i/ready_o    cfg_data_i: target_tag
//
// One byte word per cycle while no tlast byte waits behind a stalled result word;
// each byte is held in the input register and the parser updates its state in one pass.
// A result word is registered in the output register when the parser consumes the tlast byte.
// A stalled result word stops the parser only when a tlast byte is waiting
// behind it.
// Reset returns the frame state to the start and target_tag to 0x82.
// ----------------------------------------------------------------------------
module ber_tlv_tag_locator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,    // [1:0] status, [17:2] value_offset,
                                       // [33:18] value_length, [39:34] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic [btl_pkg::ByteW-1:0] target_tag_q;
  logic                      in_valid;
  logic [btl_pkg::ByteW-1:0] in_byte;
  logic                      in_last;
  logic                      out_free;
  logic                      consume;
  btl_pkg::btl_result_t      result;
  btl_pkg::btl_result_t      out_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_tag_q <= btl_pkg::TargetTagReset;
    end else if (cfg_valid_i) begin
      target_tag_q <= cfg_data_i;
    end
  end

  // advance a byte only when its result, if any, has room
  assign consume = in_valid && (!in_last || out_free);

  btl_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .consume_i  (consume),
    .valid_o    (in_valid),
    .byte_o     (in_byte),
    .last_o     (in_last)
  );

  btl_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (consume),
    .byte_i       (in_byte),
    .last_i       (in_last),
    .target_tag_i (target_tag_q),
    .result_o     (result)
  );

  btl_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (consume && in_last),
    .result_i (result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {6'd0, out_result};

endmodule

/* sv/btl_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV input register
// Holds one incoming byte word until the parser consumes it.
// ----------------------------------------------------------------------------
module btl_in_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [btl_pkg::ByteW-1:0] in_byte_i,
  input  logic                     in_last_i,
  input  logic                     consume_i,
  output logic                     valid_o,
  output logic [btl_pkg::ByteW-1:0] byte_o,
  output logic                     last_o
);

  logic                      valid_q, valid_d;
  logic [btl_pkg::ByteW-1:0] byte_q;
  logic                      last_q;
  logic                      load;

  assign in_ready_o = !valid_q || consume_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

/* sv/btl_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV parser
// Per-byte tag/length/value state update and end-of-frame result.
// ----------------------------------------------------------------------------
module btl_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [btl_pkg::ByteW-1:0]  byte_i,
  input  logic                       last_i,
  input  logic [btl_pkg::ByteW-1:0]  target_tag_i,
  output btl_pkg::btl_result_t       result_o
);

  logic [btl_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [btl_pkg::PosW-1:0]    pos_q, pos_d;
  logic [btl_pkg::PosW-1:0]    acc_q, acc_d;
  logic [1:0]                  left_q, left_d;
  logic [btl_pkg::PosW-1:0]    skip_q, skip_d;
  logic                        matched_q, matched_d;
  logic                        constr_q, constr_d;
  logic [btl_pkg::PosW-1:0]    foff_q, foff_d;
  logic [btl_pkg::PosW-1:0]    flen_q, flen_d;
  logic [btl_pkg::StatusW-1:0] fstat_q, fstat_d;

  logic                        lk_fire;
  logic [btl_pkg::PosW-1:0]    lk_len;
  logic [btl_pkg::PosW-1:0]    acc_new;
  logic [6:0]                  len_cnt;
  logic [btl_pkg::StatusW-1:0] st;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q + 16'd1;
    acc_d     = acc_q;
    left_d    = left_q;
    skip_d    = skip_q;
    matched_d = matched_q;
    constr_d  = constr_q;
    foff_d    = foff_q;
    flen_d    = flen_q;
    fstat_d   = fstat_q;
    lk_fire   = 1'b0;
    lk_len    = '0;
    acc_new   = {acc_q[7:0], byte_i};
    len_cnt   = byte_i[6:0] & btl_pkg::LenCountMask[6:0];

    case (phase_q)
      btl_pkg::PhTag: begin
        matched_d = (byte_i == target_tag_i);
        constr_d  = (byte_i == btl_pkg::TagAppl0) || (byte_i == btl_pkg::TagCtx2);
        phase_d   = btl_pkg::PhLen;
      end
      btl_pkg::PhLen: begin
        if ((byte_i & btl_pkg::LongFormBit) != '0) begin
          if (len_cnt > btl_pkg::MaxLenBytes) begin
            fstat_d = btl_pkg::StLongLen;
            phase_d = btl_pkg::PhDone;
          end else if (len_cnt == 7'd0) begin
            lk_fire = 1'b1;
          end else begin
            acc_d   = '0;
            left_d  = len_cnt[1:0];
            phase_d = btl_pkg::PhLenx;
          end
        end else begin
          lk_fire = 1'b1;
          lk_len  = {8'd0, byte_i};
        end
      end
      btl_pkg::PhLenx: begin
        acc_d  = acc_new;
        left_d = left_q - 2'd1;
        if (left_d == 2'd0) begin
          lk_fire = 1'b1;
          lk_len  = acc_new;
        end
      end
      btl_pkg::PhSkip: begin
        skip_d = skip_q - 16'd1;
        if (skip_d == '0) begin
          phase_d = btl_pkg::PhTag;
        end
      end
      btl_pkg::PhValue: begin
        skip_d = skip_q - 16'd1;
        if (skip_d == '0) begin
          fstat_d = btl_pkg::StFound;
          phase_d = btl_pkg::PhDone;
        end
      end
      default: begin
      end
    endcase

    // length now known: record a match, enter a constructed or empty tag, or skip
    if (lk_fire) begin
      if (matched_q) begin
        foff_d = pos_d;
        flen_d = lk_len;
        if (lk_len == '0) begin
          fstat_d = btl_pkg::StFound;
          phase_d = btl_pkg::PhDone;
        end else begin
          skip_d  = lk_len;
          phase_d = btl_pkg::PhValue;
        end
      end else if (constr_q || lk_len == '0) begin
        phase_d = btl_pkg::PhTag;
      end else begin
        skip_d  = lk_len;
        phase_d = btl_pkg::PhSkip;
      end
    end

    if (phase_d == btl_pkg::PhDone) begin
      st = fstat_d;
    end else if (phase_d == btl_pkg::PhTag || phase_d == btl_pkg::PhSkip) begin
      st = btl_pkg::StAbsent;
    end else begin
      st = btl_pkg::StTrunc;
    end

    result_o.status       = st;
    result_o.value_offset = (st == btl_pkg::StFound) ? foff_d : '0;
    result_o.value_length = (st == btl_pkg::StFound) ? flen_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= btl_pkg::PhTag;
      pos_q     <= '0;
      acc_q     <= '0;
      left_q    <= '0;
      skip_q    <= '0;
      matched_q <= 1'b0;
      constr_q  <= 1'b0;
      foff_q    <= '0;
      flen_q    <= '0;
      fstat_q   <= btl_pkg::StAbsent;
    end else if (en_i) begin
      if (last_i) begin
        // end of frame: back to the start state for the next APDU
        phase_q   <= btl_pkg::PhTag;
        pos_q     <= '0;
        acc_q     <= '0;
        left_q    <= '0;
        skip_q    <= '0;
        matched_q <= 1'b0;
        constr_q  <= 1'b0;
        foff_q    <= '0;
        flen_q    <= '0;
        fstat_q   <= btl_pkg::StAbsent;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        acc_q     <= acc_d;
        left_q    <= left_d;
        skip_q    <= skip_d;
        matched_q <= matched_d;
        constr_q  <= constr_d;
        foff_q    <= foff_d;
        flen_q    <= flen_d;
        fstat_q   <= fstat_d;
      end
    end
  end

endmodule

/* sv/btl_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module btl_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  btl_pkg::btl_result_t result_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output btl_pkg::btl_result_t result_o
);

  logic                 valid_q, valid_d;
  btl_pkg::btl_result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

/* sv/btl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV tag locator port checker
// Watches the top-level ports for ordering and result consistency.
// ----------------------------------------------------------------------------
module btl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic [1:0] pending_q;
  logic       frame_in;
  logic       word_out;

  assign frame_in = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign word_out = m_axis_tvalid && m_axis_tready;

  // frames accepted but whose result word has not left yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, frame_in} - {1'b0, word_out};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 2'd0)
    else $error("result word without an accepted frame end");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more frames in flight than the block can hold");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != btl_pkg::StFound
      |-> m_axis_tdata[33:2] == 32'd0)
    else $error("offset or length set without a find");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
    else $error("padding bits not zero");

endmodule

bind ber_tlv_tag_locator_top btl_checker u_btl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV tag locator testbench
// Streams BER encoded APDUs byte by byte into the locator and checks each
// result word against a cycle-free model of the tag search. Covers directed
// edge frames and random frames built mostly of well-formed TLVs under
// several target tags, with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import btl_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandItems   = 650;
  localparam int unsigned NumPhases   = 6;

  // --------------------------------------------------------------------------
  // Tag search scoreboard: tracks the parse of the current APDU and holds the
  // result words still owed by the block.
  // --------------------------------------------------------------------------
  class tag_scoreboard;
    logic [ByteW-1:0]   target;
    logic [PhaseW-1:0]  phase;
    logic [PosW-1:0]    pos;
    logic [PosW-1:0]    len_acc;
    logic [1:0]         len_left;
    logic [PosW:0]      skip_left;
    bit                 matched;
    bit                 constructed;
    logic [PosW-1:0]    found_off;
    logic [PosW-1:0]    found_len;
    logic [StatusW-1:0] final_st;
    btl_result_t        expected_q[$];
    int                 errors;
    int                 checked;

    function new();
      target  = TargetTagReset;
      errors  = 0;
      checked = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase       = PhTag;
      pos         = '0;
      len_acc     = '0;
      len_left    = '0;
      skip_left   = '0;
      matched     = 0;
      constructed = 0;
      found_off   = '0;
      found_len   = '0;
      final_st    = StAbsent;
    endfunction

    function void set_target(input logic [ByteW-1:0] t);
      target = t;
    endfunction

    function void length_known(input logic [PosW-1:0] len, input logic [PosW-1:0] next_pos);
      if (matched) begin
        found_off = next_pos;
        found_len = len;
        if (len == 0) begin
          final_st = StFound;
          phase    = PhDone;
        end else begin
          skip_left = {1'b0, len};
          phase     = PhValue;
        end
      end else if (constructed || len == 0) begin
        // descend: the children start right after the length
        phase = PhTag;
      end else begin
        skip_left = {1'b0, len};
        phase     = PhSkip;
      end
    endfunction

    function void note_byte(input logic [ByteW-1:0] b, input logic last);
      logic [PosW-1:0]    next_pos;
      logic [6:0]         n;
      logic [StatusW-1:0] st;
      btl_result_t        r;
      next_pos = pos + 1'b1;
      case (phase)
        PhTag: begin
          matched     = (b == target);
          constructed = (b == TagAppl0) || (b == TagCtx2);
          phase       = PhLen;
        end
        PhLen: begin
          if ((b & LongFormBit) != 0) begin
            n = 7'(b & LenCountMask);
            if (n > MaxLenBytes) begin
              final_st = StLongLen;
              phase    = PhDone;
            end else if (n == 0) begin
              length_known('0, next_pos);
            end else begin
              len_acc  = '0;
              len_left = n[1:0];
              phase    = PhLenx;
            end
          end else begin
            length_known({8'h00, b}, next_pos);
          end
        end
        PhLenx: begin
          len_acc  = {len_acc[7:0], b};
          len_left = len_left - 1'b1;
          if (len_left == 0) length_known(len_acc, next_pos);
        end
        PhSkip: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == 0) phase = PhTag;
        end
        PhValue: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == 0) begin
            final_st = StFound;
            phase    = PhDone;
          end
        end
        default: ;
      endcase
      pos = next_pos;
      if (last) begin
        if (phase == PhDone) st = final_st;
        else if (phase == PhTag || phase == PhSkip) st = StAbsent;
        else st = StTrunc;
        r.status       = st;
        r.value_offset = (st == StFound) ? found_off : '0;
        r.value_length = (st == StFound) ? found_len : '0;
        expected_q.push_back(r);
        clear_frame();
      end
    endfunction

    function void check_result(input logic [OutW-1:0] word);
      btl_result_t got;
      btl_result_t exp;
      got = word[$bits(btl_result_t)-1:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word: status %0d offset %0d length %0d",
                 $time, got.status, got.value_offset, got.value_length);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp.status, got.status);
        errors++;
      end
      if (got.value_offset !== exp.value_offset) begin
        $display("%0t: value_offset mismatch: expected %0d, actual %0d",
                 $time, exp.value_offset, got.value_offset);
        errors++;
      end
      if (got.value_length !== exp.value_length) begin
        $display("%0t: value_length mismatch: expected %0d, actual %0d",
                 $time, exp.value_length, got.value_length);
        errors++;
      end
      if (word[OutW-1:$bits(btl_result_t)] !== '0) begin
        $display("%0t: pad bits mismatch: expected 0, actual %0h",
                 $time, word[OutW-1:$bits(btl_result_t)]);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata = '0;
  logic            s_axis_tlast = 1'b0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [7:0]      cfg_data_i = '0;

  tag_scoreboard   sb;
  logic [7:0]      frame_q[$];
  bit              no_idle = 0;
  int unsigned     stall_cycles = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     frames_sent = 0;

  always #2 clk_i = ~clk_i;

  ber_tlv_tag_locator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // result side backpressure
  always @(negedge clk_i) begin
    m_axis_tready = no_idle || ($urandom_range(0, 99) >= 20);
  end

  // sample every handshake at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_target(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_byte(s_axis_tdata, s_axis_tlast);
        bytes_sent++;
        if (s_axis_tlast) frames_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  initial begin
    wait (rst_ni);
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("Timeout: %0d cycles without a handshake", StallLimit);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!no_idle && $urandom_range(0, 99) < 20) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = l;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // wait out every owed result word plus the pipeline depth
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [7:0] t);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = t;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly well-formed TLV chains with random content; some pure noise,
  // some cut short, some with trailing junk.
  task automatic build_frame();
    logic [7:0]  tag;
    logic [15:0] len;
    int          form;
    int          keep;
    bit          cut;
    frame_q.delete();
    cut = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) frame_q.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if (!cut) begin
          case ($urandom_range(0, 9))
            0, 1, 2: tag = sb.target;
            3:       tag = TagAppl0;
            4:       tag = TagCtx2;
            default: tag = rand_byte();
          endcase
          frame_q.push_back(tag);
          len  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 6));
          form = $urandom_range(0, 7);
          if (form == 0) begin
            // too many length bytes: the rest of the frame is dead
            frame_q.push_back(LongFormBit | 8'($urandom_range(3, 127)));
            cut = 1;
          end else if (form == 1 && len == 0) begin
            frame_q.push_back(LongFormBit);
          end else if (form == 2 && len < 256) begin
            frame_q.push_back(LongFormBit | 8'd1);
            frame_q.push_back(len[7:0]);
          end else if (form == 3 || len >= 128) begin
            frame_q.push_back(LongFormBit | 8'd2);
            frame_q.push_back(len[15:8]);
            frame_q.push_back(len[7:0]);
          end else begin
            frame_q.push_back(len[7:0]);
          end
          // constructed tags carry their children inline, not a value
          if (!cut && (tag == sb.target || !(tag == TagAppl0 || tag == TagCtx2))) begin
            if (len <= 24) begin
              repeat (len) frame_q.push_back(rand_byte());
            end else begin
              repeat ($urandom_range(0, 8)) frame_q.push_back(rand_byte());
              cut = 1;
            end
          end
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        keep = $urandom_range(1, frame_q.size());
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) frame_q.push_back(rand_byte());
    end
  endtask

  initial begin
    logic [7:0]  phase_targets[NumPhases];
    int unsigned start;
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames, all but the last under the reset target
    frame_q = '{8'h82, 8'h00};                      send_frame(); // empty value, offset at end
    frame_q = '{8'h82};                             send_frame(); // ends after tag
    frame_q = '{8'hFF, 8'h83, 8'h00};               send_frame(); // long length, junk ignored
    frame_q = '{8'hA2, 8'h81, 8'h03, 8'h82, 8'h01, 8'hFF};
    send_frame();                                                 // descend, then find
    frame_q = '{8'h04, 8'h80, 8'h60, 8'h82, 8'h00, 8'h00};
    send_frame();                                                 // zero-byte long form, inside
    frame_q = '{8'h04, 8'h05, 8'h00};               send_frame(); // skip runs past end
    frame_q = '{8'h82, 8'h02, 8'hAA};               send_frame(); // match runs past end
    frame_q = '{8'h82, 8'h82, 8'h01};               send_frame(); // ends in length bytes
    write_target(TagAppl0);
    frame_q = '{8'h60, 8'h01, 8'h00};               send_frame(); // match beats descent

    phase_targets = '{8'h00, 8'hFF, TagCtx2, TargetTagReset, rand_byte(), rand_byte()};
    for (int p = 0; p < NumPhases; p++) begin
      write_target(phase_targets[p]);
      no_idle = (p == 2);
      start = bytes_sent;
      while (bytes_sent - start < RandItems / NumPhases) begin
        build_frame();
        send_frame();
      end
    end
    no_idle = 0;
    drain();

    $display("Sent %0d bytes in %0d frames, checked %0d result words", bytes_sent,
             frames_sent, sb.checked);
    $display("Targets included 0x00, 0xFF, 0x60, 0xA2, 0x82 over directed and random frames");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/btl_pkg.sv
sv/btl_in_reg.sv
sv/btl_parser.sv
sv/btl_out_reg.sv
sv/ber_tlv_tag_locator_top.sv
sv/btl_checker.sv
dv/testbench.sv
